// ===== sv/mofb_pkg.sv =====
// shared types and constants for the masked overlay feather blend
`default_nettype none
package mofb_pkg;
  localparam int unsigned MaxLineDef = 4096;
  localparam int unsigned SampleBitsDef = 32;

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_LEAVE   = 2'd1,
    MODE_AVERAGE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SRC_BASE  = 2'd0,
    SRC_INSET = 2'd1,
    SRC_BLEND = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    CFG_MASK = 2'd0,
    CFG_MODE = 2'd1
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } div_state_e;
endpackage
`default_nettype wire

// ===== sv/mofb_front.sv =====
// front end: classifies beats, keeps the line counters, builds the jobs for compose beats
`default_nettype none
module mofb_front #(
  parameter int unsigned MaxLine = mofb_pkg::MaxLineDef,
  parameter int unsigned SampleBits = mofb_pkg::SampleBitsDef,
  parameter int unsigned CntW = $clog2(MaxLine + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         op_i,
  input  wire logic                         first_i,
  input  wire logic signed [SampleBits-1:0] inset_i,
  input  wire logic signed [SampleBits-1:0] base_i,
  input  wire logic                         left_i,
  input  wire logic signed [SampleBits-1:0] mask_i,
  input  wire mofb_pkg::mode_e              mode_i,
  output logic                              job_valid_o,
  input  wire logic                         job_ready_i,
  output logic [2*SampleBits+2*CntW+3:0]    job_o
);
  import mofb_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic ins_ok, bas_ok, fire;
  logic [CntW-1:0] idx_base;
  src_e src;

  assign in_ready_o = job_ready_i;
  assign fire = in_valid_i && in_ready_o;
  assign ins_ok = inset_i != mask_i;
  assign bas_ok = base_i != mask_i;
  assign idx_base = first_i ? '0 : idx_q;

  // classify and advance counters
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    src = SRC_BASE;
    if (!op_i) begin
      cnt_d = first_i ? '0 : cnt_q;
      if (ins_ok && bas_ok && cnt_d < CntW'(MaxLine)) cnt_d = cnt_d + 1'b1;
    end else begin
      idx_d = idx_base;
      if (ins_ok) begin
        unique case (mode_i)
          MODE_REPLACE: src = SRC_INSET;
          MODE_LEAVE:   src = bas_ok ? SRC_BASE : SRC_INSET;
          MODE_AVERAGE: begin
            if (!bas_ok) src = SRC_INSET;
            else begin
              src = SRC_BLEND;
              if (idx_base < cnt_q) idx_d = idx_base + 1'b1;
            end
          end
          default: src = SRC_BASE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (fire) begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // job: left, src, a zero bit, k, n, base, inset
  assign job_valid_o = in_valid_i && op_i;
  assign job_o = {left_i, src, 1'b0, idx_d, cnt_q, base_i, inset_i};
endmodule
`default_nettype wire

// ===== sv/mofb_fifo.sv =====
// two-entry queue between the front and the back end
`default_nettype none
module mofb_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [Width-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic [Width-1:0]      rd_data_o
);
  logic [Width-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== sv/mofb_back.sv =====
// back end: passes copied and kept samples, weighted sum and restoring division for blended beats
`default_nettype none
module mofb_back #(
  parameter int unsigned SampleBits = mofb_pkg::SampleBitsDef,
  parameter int unsigned CntW = 13
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            job_valid_i,
  output logic                                 job_ready_o,
  input  wire logic [2*SampleBits+2*CntW+3:0]  job_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [SampleBits-1:0]         out_sample_o,
  output mofb_pkg::src_e                       out_src_o
);
  import mofb_pkg::*;

  localparam int unsigned DW = CntW + 1;
  localparam int unsigned PW = SampleBits + DW + 1;
  localparam int unsigned QW = PW;
  localparam int unsigned SW = $clog2(QW + 1);

  logic signed [SampleBits-1:0] ins, bas;
  logic [CntW-1:0] n, k;
  logic left;
  src_e jsrc;

  assign ins = job_i[SampleBits-1:0];
  assign bas = job_i[2*SampleBits-1:SampleBits];
  assign n = job_i[2*SampleBits+CntW-1:2*SampleBits];
  assign k = job_i[2*SampleBits+2*CntW-1:2*SampleBits+CntW];
  assign jsrc = src_e'(job_i[2*SampleBits+2*CntW+2:2*SampleBits+2*CntW+1]);
  assign left = job_i[2*SampleBits+2*CntW+3];

  div_state_e st_q, st_d;
  logic [DW-1:0] d_q, wb_q;
  logic signed [SampleBits-1:0] ins_q, bas_q;
  logic neg_q;
  logic [QW-1:0] quo_q, quo_d;
  logic [DW:0] rem_q, rem_d;
  logic [SW-1:0] step_q, step_d;
  logic signed [SampleBits-1:0] res_q, res_d;
  src_e src_q, src_d;
  logic signed [PW-1:0] prod, mag_prod;
  logic signed [SampleBits:0] diff;
  logic [DW:0] trial;
  logic [DW-1:0] d_w, wb_w;

  // sum = d*ins + wb*(bas-ins), two multiplies
  assign diff = {bas_q[SampleBits-1], bas_q} - {ins_q[SampleBits-1], ins_q};
  assign prod = PW'($signed({1'b0, wb_q})) * PW'(diff)
              + PW'($signed({1'b0, d_q})) * PW'(ins_q);
  assign mag_prod = prod[PW-1] ? -prod : prod;
  assign d_w = DW'(n) + DW'(1);
  assign wb_w = left ? DW'(k) : d_w - DW'(k);
  assign trial = {rem_q[DW-1:0], quo_q[QW-1]} - {1'b0, d_q};

  // sequencer
  always_comb begin
    st_d = st_q;
    quo_d = quo_q;
    rem_d = rem_q;
    step_d = step_q;
    res_d = res_q;
    src_d = src_q;
    job_ready_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          src_d = jsrc;
          unique case (jsrc)
            SRC_INSET: begin res_d = ins; st_d = ST_OUT; end
            SRC_BLEND: st_d = ST_MUL;
            default:   begin res_d = bas; st_d = ST_OUT; end
          endcase
        end
      end
      ST_MUL: begin
        quo_d = QW'(mag_prod);
        rem_d = '0;
        step_d = SW'(QW);
        st_d = ST_DIV;
      end
      ST_DIV: begin
        if (trial[DW]) begin
          rem_d = {rem_q[DW-1:0], quo_q[QW-1]};
          quo_d = {quo_q[QW-2:0], 1'b0};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[QW-2:0], 1'b1};
        end
        step_d = step_q - 1'b1;
        if (step_q == SW'(1)) begin
          res_d = neg_q ? -SampleBits'(quo_d) : SampleBits'(quo_d);
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    step_q <= step_d;
    res_q <= res_d;
    src_q <= src_d;
    if (st_q == ST_IDLE) begin
      ins_q <= ins;
      bas_q <= bas;
      d_q <= d_w;
      wb_q <= wb_w;
    end
    if (st_q == ST_MUL) neg_q <= prod[PW-1];
  end

  assign out_valid_o = st_q == ST_OUT;
  assign out_sample_o = res_q;
  assign out_src_o = src_q;
endmodule
`default_nettype wire

// ===== sv/masked_overlay_feather_blend.sv =====
// top level of the masked overlay feather blend
//
// Survey beats (op 0) are absorbed while the queue has room and produce
// nothing. Compose beats give one result each. The back end works on one
// job at a time. A copied or kept sample occupies it while it takes the job
// and presents the result. A blended sample occupies it while it takes the
// job, forms the weighted sum, divides it by n+1 in a bit-serial divider at
// one quotient bit per cycle, and presents the result. A stalling receiver
// holds the back end in its output state. A two-entry queue lets survey
// beats and classification continue while a division runs.
`default_nettype none
module masked_overlay_feather_blend #(
  parameter int unsigned MaxLine = mofb_pkg::MaxLineDef,
  parameter int unsigned SampleBits = mofb_pkg::SampleBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // first_of_line, inset_sample, base_sample, left_ramp, 6 zero bits
  input  wire logic [71:0] s_axis_tdata,
  // op
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_sample
  output logic [31:0]      m_axis_tdata,
  // source
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import mofb_pkg::*;

  localparam int unsigned CntW = $clog2(MaxLine + 1);
  localparam int unsigned JW = 2*SampleBits + 2*CntW + 4;

  logic [31:0] mask_q;
  mode_e mode_q;
  logic signed [SampleBits-1:0] mask_s, ins_s, bas_s, res_s;
  logic jv, jr, qv, qr;
  logic [JW-1:0] job, qjob;
  src_e src;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      mode_q <= MODE_REPLACE;
    end else if (cfg_we_i) begin
      unique case (cfg_e'({1'b0, cfg_addr_i}))
        CFG_MASK: mask_q <= cfg_wdata_i;
        CFG_MODE: mode_q <= mode_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  assign mask_s = mask_q[SampleBits-1:0];
  assign ins_s = s_axis_tdata[1+SampleBits-1:1];
  assign bas_s = s_axis_tdata[33+SampleBits-1:33];

  mofb_front #(.MaxLine(MaxLine), .SampleBits(SampleBits), .CntW(CntW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .op_i(s_axis_tuser[0]), .first_i(s_axis_tdata[0]),
    .inset_i(ins_s), .base_i(bas_s), .left_i(s_axis_tdata[65]),
    .mask_i(mask_s), .mode_i(mode_q),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  mofb_fifo #(.Width(JW)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(jv), .wr_ready_o(jr), .wr_data_i(job),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qjob)
  );

  mofb_back #(.SampleBits(SampleBits), .CntW(CntW)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(qv), .job_ready_o(qr), .job_i(qjob),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_sample_o(res_s), .out_src_o(src)
  );

  assign m_axis_tdata = 32'(res_s);
  assign m_axis_tuser = src;

  // checks
  ap_src_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> src != 2'd3) else $error("bad source code");
  ap_survey_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tuser[0]) |-> !jv) else $error("survey made a job");
  ap_ready_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == jr) else $error("front ready mismatch");
endmodule
`default_nettype wire

// ===== verif/masked_overlay_feather_blend_tb.sv =====
// testbench for the masked overlay feather blend: directed and random streams checked against a predictor
`default_nettype none
module masked_overlay_feather_blend_tb;
  import mofb_pkg::*;

  typedef struct packed {
    logic        left_ramp;
    logic [31:0] base_sample;
    logic [31:0] inset_sample;
    logic        first_of_line;
    logic        op;
  } pix_t;

  typedef struct {
    logic [31:0] sample;
    src_e        src;
  } out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  masked_overlay_feather_blend u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [31:0] cur_mask = '0;
  mode_e       cur_mode = MODE_REPLACE;
  int unsigned n_overlap = 0;
  int unsigned k_blend = 0;

  pix_t pending_q[$];
  out_t expected_q[$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_cycles = 0;
  longint cycles = 0;
  logic in_acc = 1'b0;

  // work out the result of one accepted beat
  task automatic predict_pixel(input pix_t p);
    longint ins, bas, d, k, wb;
    bit ins_ok, bas_ok;
    out_t r;
    ins = longint'($signed(p.inset_sample));
    bas = longint'($signed(p.base_sample));
    ins_ok = p.inset_sample != cur_mask;
    bas_ok = p.base_sample != cur_mask;
    if (!p.op) begin
      if (p.first_of_line) n_overlap = 0;
      if (ins_ok && bas_ok && n_overlap < MaxLineDef) n_overlap++;
      return;
    end
    if (p.first_of_line) k_blend = 0;
    r.sample = p.base_sample;
    r.src = SRC_BASE;
    if (ins_ok) begin
      if (cur_mode == MODE_REPLACE || ((cur_mode == MODE_LEAVE || cur_mode == MODE_AVERAGE)
          && !bas_ok)) begin
        r.sample = p.inset_sample;
        r.src = SRC_INSET;
      end else if (cur_mode == MODE_AVERAGE) begin
        if (k_blend < n_overlap) k_blend++;
        d = n_overlap + 1;
        k = k_blend;
        wb = p.left_ramp ? k : d - k;
        r.sample = 32'((wb * bas + (d - wb) * ins) / d);
        r.src = SRC_BLEND;
      end
    end
    expected_q.push_back(r);
  endtask

  // input acceptance as seen at the clock edge
  always @(posedge clk_i) in_acc = rst_ni && s_axis_tvalid && s_axis_tready;

  // driver: offer beats from the pending queue
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_acc) begin
        predict_pixel(pending_q[0]);
        void'(pending_q.pop_front());
      end
      if (pending_q.size() > 0 && ((s_axis_tvalid && !in_acc) ||
          $urandom_range(99) >= send_idle_pct)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_q[0].op;
        s_axis_tdata <= {6'd0, pending_q[0].left_ramp, pending_q[0].base_sample,
                         pending_q[0].inset_sample, pending_q[0].first_of_line};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure and a long hold
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h source %0d", m_axis_tdata, m_axis_tuser);
      end else begin
        if (m_axis_tdata !== expected_q[0].sample || m_axis_tuser !== expected_q[0].src) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected sample %h source %0d, got %h source %0d",
                     expected_q[0].sample, expected_q[0].src, m_axis_tdata, m_axis_tuser);
        end
        void'(expected_q.pop_front());
      end
    end
    if (cycles > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // wait until the block has drained, then a latency margin
  task automatic drain;
    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx[0:0];
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MASK) cur_mask = val;
    else cur_mode = mode_e'(val[1:0]);
  endtask

  function automatic logic [31:0] pick_sample(input logic [31:0] msk);
    case ($urandom_range(5))
      0, 1:    return msk;
      2:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      3:       return 32'($signed($urandom_range(40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  // one line: survey pass then compose pass, sometimes broken
  task automatic push_line(input int len);
    pix_t line[$];
    pix_t p;
    bit ramp;
    ramp = $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      p.op = 1'b0;
      p.first_of_line = (i == 0);
      p.inset_sample = pick_sample(cur_mask);
      p.base_sample = pick_sample(cur_mask);
      p.left_ramp = ramp;
      line.push_back(p);
    end
    if ($urandom_range(9) != 0) foreach (line[i]) pending_q.push_back(line[i]);
    foreach (line[i]) begin
      p = line[i];
      p.op = 1'b1;
      if ($urandom_range(15) == 0) p.inset_sample = $urandom;
      pending_q.push_back(p);
    end
  endtask

  initial begin
    pix_t p;
    logic [31:0] masks[4];
    masks = '{32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes in each mode, no survey, over-count
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_MODE, 32'(m));
      foreach (masks[j]) if (j < 2 || m == 2) begin
        p = '{left_ramp: j[0], base_sample: 32'h7fff_ffff, inset_sample: 32'h8000_0000,
              first_of_line: 1'b1, op: 1'b1};
        pending_q.push_back(p);
      end
      p = '{1'b0, 32'd0, 32'd5, 1'b0, 1'b1};
      pending_q.push_back(p);
      p = '{1'b1, 32'd5, 32'd0, 1'b0, 1'b0};
      pending_q.push_back(p);
      drain();
    end

    // random phases across masks, modes and idling
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(CFG_MASK, ph % 5 == 4 ? $urandom : masks[ph % 4]);
      write_reg(CFG_MODE, ph % 3 == 0 ? MODE_AVERAGE : $urandom_range(3));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 87; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 87; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (ph == 4) hold_cycles = 400;
      for (int l = 0; l < 8; l++) push_line($urandom_range(9) == 0 ? 40 : $urandom_range(1, 8));
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
